// File: rtl/core/gpljg_pkg.sv
// gpljg_pkg: shared constants, the fixed gait breakpoint table and the
// command/status structs between the gait controller and its datapath.
// No dependencies.
package gpljg_pkg;

  // Geometry
  localparam int unsigned NUM_LEGS       = 6;
  localparam int unsigned LEGS_PER_GROUP = 3;
  localparam int unsigned JOINTS_PER_LEG = 3;
  localparam int unsigned BREAKPOINTS    = 7;
  localparam int unsigned NUM_ENGINES    = NUM_LEGS * JOINTS_PER_LEG;

  // Field widths
  localparam int unsigned LEG_W    = 3;
  localparam int unsigned PHASE_W  = 10;   // log2 of samples per step
  localparam int unsigned PER_W    = 24;
  localparam int unsigned SPP_W    = 5;
  localparam int unsigned PROD_W   = PER_W + SPP_W;
  localparam int unsigned STEP_W   = 19;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned ANG_W    = 7;
  localparam int unsigned SAMP_W   = 11;
  localparam int unsigned TANG_W   = 8;    // table angle width
  localparam int unsigned MAG_W    = 7;
  localparam int unsigned NUM_W    = PHASE_W + MAG_W;
  localparam int unsigned REM_W    = NUM_W + 1;
  localparam int unsigned QUO_W    = 7;    // quotient never exceeds the span magnitude
  localparam int unsigned BIT_W    = 3;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned BP_W     = 3;
  localparam int unsigned EIDX_W   = 5;

  localparam logic [SPP_W-1:0] SPP_RESET = 5'd5;

  // Breakpoint sample positions, per joint
  function automatic logic [SAMP_W-1:0] bp_sample(input logic [SEL_W-1:0] j,
                                                  input logic [BP_W-1:0]  k);
    logic [SAMP_W-1:0] s;
    case (k)
      3'd0:    s = 11'd0;
      3'd1:    s = 11'd85;
      3'd2:    s = 11'd427;
      3'd3:    s = 11'd512;
      3'd4:    s = 11'd597;
      3'd5:    s = 11'd939;
      default: s = 11'd1024;
    endcase
    if (j > 2'd2) s = 11'd1024;
    return s;
  endfunction

  // Breakpoint angles in degrees, per joint
  function automatic logic signed [TANG_W-1:0] bp_angle(input logic [SEL_W-1:0] j,
                                                        input logic [BP_W-1:0]  k);
    logic signed [TANG_W-1:0] a;
    case (j)
      2'd0: begin
        case (k)
          3'd2, 3'd3, 3'd4: a = -8'sd20;
          default:          a = 8'sd20;
        endcase
      end
      2'd1: begin
        case (k)
          3'd1, 3'd2: a = 8'sd10;
          default:    a = 8'sd45;
        endcase
      end
      default: a = 8'sd45;
    endcase
    return a;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic             load;     // capture input word
    logic             mul;      // periods * speed
    logic             phase;    // phase and step count
    logic             setup;    // segment lookup, divider init
    logic             div;      // one quotient bit
    logic             commit;   // store new angle, rotate pending word
    logic             flush;    // push pending word as final of the run
    logic [SEL_W-1:0] leg_sel;
    logic [SEL_W-1:0] joint_sel;
    logic [BIT_W-1:0] div_bit;
  } gpljg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic leg_ok;    // selected leg number is in range
    logic diff;      // angle differs from stored one
    logic pend_vld;  // a word is held back for last-of-run marking
    logic can_push;  // output register can take a word this cycle
  } gpljg_sts_t;

endpackage

// File: rtl/core/gpljg_ctrl.sv
// gpljg_ctrl: sequencer for one gait update: leg/joint loop and divider
// bit counter. Depends on gpljg_pkg.
module gpljg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gpljg_pkg::gpljg_sts_t sts_i,
  output gpljg_pkg::gpljg_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_PHASE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  localparam logic [gpljg_pkg::SEL_W-1:0] LAST_LEG   =
    gpljg_pkg::SEL_W'(gpljg_pkg::LEGS_PER_GROUP - 1);
  localparam logic [gpljg_pkg::SEL_W-1:0] LAST_JOINT =
    gpljg_pkg::SEL_W'(gpljg_pkg::JOINTS_PER_LEG - 1);
  localparam logic [gpljg_pkg::BIT_W-1:0] TOP_BIT    =
    gpljg_pkg::BIT_W'(gpljg_pkg::QUO_W - 1);

  logic [2:0]                    state_q, state_d;
  logic [gpljg_pkg::SEL_W-1:0]   leg_q, leg_d;
  logic [gpljg_pkg::SEL_W-1:0]   joint_q, joint_d;
  logic [gpljg_pkg::BIT_W-1:0]   bit_q, bit_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    leg_d   = leg_q;
    joint_d = joint_q;
    bit_d   = bit_q;
    cmd_o   = '0;
    cmd_o.leg_sel   = leg_q;
    cmd_o.joint_sel = joint_q;
    cmd_o.div_bit   = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PHASE;
      end
      S_PHASE: begin
        cmd_o.phase = 1'b1;
        leg_d       = '0;
        joint_d     = '0;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.leg_ok) begin
          state_d = S_SETUP;
        end else if (leg_q == LAST_LEG) begin
          state_d = S_FLUSH;
        end else begin
          leg_d = leg_q + 1'b1;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        bit_d       = TOP_BIT;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        bit_d     = bit_q - 1'b1;
        if (bit_q == '0) state_d = S_CMP;
      end
      S_CMP: begin
        // a changed angle waits here while a word is pending and the output is blocked
        cmd_o.commit = sts_i.diff && (!sts_i.pend_vld || sts_i.can_push);
        if (!sts_i.diff || cmd_o.commit) begin
          if (joint_q == LAST_JOINT) begin
            joint_d = '0;
            if (leg_q == LAST_LEG) begin
              state_d = S_FLUSH;
            end else begin
              leg_d   = leg_q + 1'b1;
              state_d = S_CHECK;
            end
          end else begin
            joint_d = joint_q + 1'b1;
            state_d = S_SETUP;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.flush = sts_i.pend_vld && sts_i.can_push;
        if (!sts_i.pend_vld || sts_i.can_push) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      leg_q   <= '0;
      joint_q <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
      joint_q <= joint_d;
      bit_q   <= bit_d;
    end
  end

endmodule

// File: rtl/core/gpljg_dp.sv
// gpljg_dp: phase multiplier, segment lookup, bit-serial divider, last-angle
// store and output word registers. Depends on gpljg_pkg.
module gpljg_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gpljg_pkg::SPP_W-1:0]           cfg_wdata_i,
  input  logic [gpljg_pkg::LEG_W-1:0]           leg_a_i,
  input  logic [gpljg_pkg::LEG_W-1:0]           leg_b_i,
  input  logic [gpljg_pkg::LEG_W-1:0]           leg_c_i,
  input  logic [gpljg_pkg::PHASE_W-1:0]         phase_offset_i,
  input  logic [gpljg_pkg::PER_W-1:0]           elapsed_periods_i,
  input  gpljg_pkg::gpljg_cmd_t                 cmd_i,
  output gpljg_pkg::gpljg_sts_t                 sts_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [gpljg_pkg::ID_W-1:0]            engine_id_o,
  output logic signed [gpljg_pkg::ANG_W-1:0]    angle_o,
  output logic [gpljg_pkg::STEP_W-1:0]          steps_done_o,
  output logic                                  last_of_run_o
);

  localparam int unsigned NBP = gpljg_pkg::BREAKPOINTS;
  localparam logic [gpljg_pkg::BP_W-1:0] LAST_BP = gpljg_pkg::BP_W'(NBP - 1);

  // Configuration
  logic [gpljg_pkg::SPP_W-1:0] spp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spp_q <= gpljg_pkg::SPP_RESET;
    else if (cfg_we_i) spp_q <= cfg_wdata_i;
  end

  // Captured input word
  logic [gpljg_pkg::LEG_W-1:0]   leg_q [gpljg_pkg::LEGS_PER_GROUP];
  logic [gpljg_pkg::PHASE_W-1:0] offset_q;
  logic [gpljg_pkg::PER_W-1:0]   periods_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      leg_q[0]  <= leg_a_i;
      leg_q[1]  <= leg_b_i;
      leg_q[2]  <= leg_c_i;
      offset_q  <= phase_offset_i;
      periods_q <= elapsed_periods_i;
    end
  end

  // Sample count, then phase and step count
  logic [gpljg_pkg::PROD_W-1:0]  prod_q;
  logic [gpljg_pkg::PHASE_W-1:0] phase_q;
  logic [gpljg_pkg::STEP_W-1:0]  step_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= periods_q * gpljg_pkg::PROD_W'(spp_q);
    if (cmd_i.phase) phase_q <= offset_q + prod_q[gpljg_pkg::PHASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.phase && (offset_q == '0)) begin
      step_q <= prod_q[gpljg_pkg::PHASE_W +: gpljg_pkg::STEP_W];
    end
  end

  // Selected leg
  logic [gpljg_pkg::LEG_W-1:0]  leg_cur;
  logic [gpljg_pkg::EIDX_W-1:0] eidx;
  logic [gpljg_pkg::ID_W-1:0]   eid;

  assign leg_cur = leg_q[cmd_i.leg_sel];
  assign eidx = gpljg_pkg::EIDX_W'(leg_cur) * gpljg_pkg::EIDX_W'(gpljg_pkg::JOINTS_PER_LEG)
              + gpljg_pkg::EIDX_W'(cmd_i.joint_sel);
  assign eid  = gpljg_pkg::ID_W'(leg_cur) * 6'd10 + gpljg_pkg::ID_W'(cmd_i.joint_sel);

  // Segment lookup: last breakpoint at or below the phase
  logic [gpljg_pkg::BP_W-1:0]          seg;
  logic [gpljg_pkg::SAMP_W-1:0]        lo_s, hi_s;
  logic signed [gpljg_pkg::TANG_W-1:0] lo_v, hi_v;
  logic signed [gpljg_pkg::TANG_W:0]   span;
  logic [gpljg_pkg::MAG_W-1:0]         mag;
  logic                                hold;

  always_comb begin
    seg = '0;
    for (int k = 1; k < NBP; k++) begin
      if (gpljg_pkg::SAMP_W'(phase_q) >= gpljg_pkg::bp_sample(cmd_i.joint_sel,
                                                              gpljg_pkg::BP_W'(k)))
        seg = gpljg_pkg::BP_W'(k);
    end
    lo_s = gpljg_pkg::bp_sample(cmd_i.joint_sel, seg);
    lo_v = gpljg_pkg::bp_angle(cmd_i.joint_sel, seg);
    hi_s = gpljg_pkg::bp_sample(cmd_i.joint_sel, seg + 1'b1);
    hi_v = gpljg_pkg::bp_angle(cmd_i.joint_sel, seg + 1'b1);
    hold = (seg == LAST_BP) || (hi_s <= lo_s);
    span = (gpljg_pkg::TANG_W+1)'(hi_v) - (gpljg_pkg::TANG_W+1)'(lo_v);
    mag  = span[gpljg_pkg::TANG_W] ? gpljg_pkg::MAG_W'(-span)
                                   : gpljg_pkg::MAG_W'(span);
  end

  // Restoring divider, one quotient bit a cycle
  logic signed [gpljg_pkg::TANG_W-1:0] base_q;
  logic                                up_q, hold_q;
  logic [gpljg_pkg::REM_W-1:0]         rem_q;
  logic [gpljg_pkg::SAMP_W-1:0]        den_q;
  logic [gpljg_pkg::QUO_W-1:0]         quo_q;
  logic [gpljg_pkg::REM_W-1:0]         den_sh;
  logic [gpljg_pkg::PHASE_W-1:0]       seg_ofs;

  assign seg_ofs = phase_q - lo_s[gpljg_pkg::PHASE_W-1:0];
  assign den_sh  = gpljg_pkg::REM_W'(den_q) << cmd_i.div_bit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      base_q <= lo_v;
      up_q   <= (lo_v < hi_v);
      hold_q <= hold;
      rem_q  <= gpljg_pkg::REM_W'(seg_ofs) * gpljg_pkg::REM_W'(mag);
      den_q  <= hi_s - lo_s;
      quo_q  <= '0;
    end else if (cmd_i.div) begin
      if (rem_q >= den_sh) begin
        rem_q                <= rem_q - den_sh;
        quo_q[cmd_i.div_bit] <= 1'b1;
      end
    end
  end

  // Interpolated angle against the stored one
  logic signed [gpljg_pkg::TANG_W-1:0] ang_full;
  logic signed [gpljg_pkg::ANG_W-1:0]  ang;
  logic signed [gpljg_pkg::ANG_W-1:0]  last_q [gpljg_pkg::NUM_ENGINES];

  always_comb begin
    if (hold_q)    ang_full = base_q;
    else if (up_q) ang_full = base_q + gpljg_pkg::TANG_W'(quo_q);
    else           ang_full = base_q - gpljg_pkg::TANG_W'(quo_q);
  end
  assign ang = ang_full[gpljg_pkg::ANG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < gpljg_pkg::NUM_ENGINES; e++) last_q[e] <= '0;
    end else if (cmd_i.commit) begin
      last_q[eidx] <= ang;
    end
  end

  // Pending word and output register; the pending one is marked last on flush
  logic                               pend_vld_q;
  logic [gpljg_pkg::ID_W-1:0]         pend_id_q;
  logic signed [gpljg_pkg::ANG_W-1:0] pend_ang_q;
  logic                               out_vld_q;
  logic                               push;

  assign push = (cmd_i.commit && pend_vld_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.commit)     pend_vld_q <= 1'b1;
      else if (cmd_i.flush) pend_vld_q <= 1'b0;
      if (push)             out_vld_q  <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pend_id_q  <= eid;
      pend_ang_q <= ang;
    end
    if (push) begin
      engine_id_o   <= pend_id_q;
      angle_o       <= pend_ang_q;
      steps_done_o  <= step_q;
      last_of_run_o <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_vld_q;

  // Status
  assign sts_o.leg_ok   = (leg_cur < gpljg_pkg::LEG_W'(gpljg_pkg::NUM_LEGS));
  assign sts_o.diff     = (ang != last_q[eidx]);
  assign sts_o.pend_vld = pend_vld_q;
  assign sts_o.can_push = !out_vld_q || !out_stall_i;

endmodule

// File: rtl/core/gait_piecewise_linear_joint_gen.sv
// Gait piecewise-linear joint generator, top level: controller plus datapath.
// A word is held back one joint so the final one can be marked.
// A new update is accepted only after the previous one is finished, output stalls
// included; the bit-serial divider is shared by all nine joints.
// Reset (rst_ni low, async): idle, last angles and step count zero, speed 5.
// Depends on gpljg_pkg, gpljg_ctrl, gpljg_dp.
module gait_piecewise_linear_joint_gen (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gpljg_pkg::SPP_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gpljg_pkg::LEG_W-1:0]        leg_a_i,
  input  logic [gpljg_pkg::LEG_W-1:0]        leg_b_i,
  input  logic [gpljg_pkg::LEG_W-1:0]        leg_c_i,
  input  logic [gpljg_pkg::PHASE_W-1:0]      phase_offset_i,
  input  logic [gpljg_pkg::PER_W-1:0]        elapsed_periods_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [gpljg_pkg::ID_W-1:0]         engine_id_o,
  output logic signed [gpljg_pkg::ANG_W-1:0] angle_o,
  output logic [gpljg_pkg::STEP_W-1:0]       steps_done_o,
  output logic                               last_of_run_o
);

  gpljg_pkg::gpljg_cmd_t cmd;
  gpljg_pkg::gpljg_sts_t sts;

  gpljg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpljg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .leg_a_i           (leg_a_i),
    .leg_b_i           (leg_b_i),
    .leg_c_i           (leg_c_i),
    .phase_offset_i    (phase_offset_i),
    .elapsed_periods_i (elapsed_periods_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .engine_id_o       (engine_id_o),
    .angle_o           (angle_o),
    .steps_done_o      (steps_done_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

// File: rtl/core/gpljg_checker.sv
// gpljg_checker: port-level assertions for the gait joint generator, bound
// to the top level. Depends on gpljg_pkg.
module gpljg_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [gpljg_pkg::ID_W-1:0]         engine_id_o,
  input logic signed [gpljg_pkg::ANG_W-1:0] angle_o,
  input logic [gpljg_pkg::STEP_W-1:0]       steps_done_o,
  input logic                               last_of_run_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(engine_id_o) &&
      $stable(angle_o) && $stable(steps_done_o) && $stable(last_of_run_o))
    else $error("stalled output word changed");

  // an accepted update keeps the input side busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // words of one run carry the same step count
  a_run_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o ##1 out_valid_o
      |-> steps_done_o == $past(steps_done_o))
    else $error("step count changed within a run");

  // a command names a real engine with a table angle
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> engine_id_o <= 6'd52 && angle_o >= -7'sd20 && angle_o <= 7'sd45)
    else $error("engine id or angle out of range");

endmodule

bind gait_piecewise_linear_joint_gen gpljg_checker u_gpljg_checker (.*);

// File: tb/sv/gait_cmd_checker.sv
`timescale 1ns / 100ps
// gait_cmd_checker: watches the update and command channels of the joint generator,
// predicts every command word from its own gait model and compares them in order.
// Depends on gpljg_pkg for field widths and geometry.
module gait_cmd_checker
  import gpljg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SPP_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [LEG_W-1:0]          leg_a_i,
  input  logic [LEG_W-1:0]          leg_b_i,
  input  logic [LEG_W-1:0]          leg_c_i,
  input  logic [PHASE_W-1:0]        phase_offset_i,
  input  logic [PER_W-1:0]          elapsed_periods_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [ID_W-1:0]           engine_id_i,
  input  logic signed [ANG_W-1:0]   angle_i,
  input  logic [STEP_W-1:0]         steps_done_i,
  input  logic                      last_of_run_i,
  output int                        fail_cnt_o,
  output int                        due_cnt_o
);

  typedef struct packed {
    logic [ID_W-1:0]   engine;
    logic [ANG_W-1:0]  angle;
    logic [STEP_W-1:0] steps;
    logic              last;
  } engine_cmd_t;

  // model state
  logic [SPP_W-1:0]  speed;
  logic [STEP_W-1:0] step_cnt;
  int                kept_angle [NUM_ENGINES];
  engine_cmd_t       cmd_due [$];

  // piecewise-linear angle of one joint at a step phase
  function automatic int joint_angle(input int joint, input int phase);
    int knot [7];
    int ang [7];
    int k;
    int mag;
    int q;
    knot = '{0, 85, 427, 512, 597, 939, 1024};
    case (joint)
      0:       ang = '{20, 20, -20, -20, -20, 20, 20};
      1:       ang = '{45, 10, 10, 45, 45, 45, 45};
      default: ang = '{45, 45, 45, 45, 45, 45, 45};
    endcase
    // last knot at or below the phase
    k = 0;
    while (k < 6 && knot[k+1] <= phase) k++;
    // beyond the last knot the angle holds
    if (k == 6) return ang[6];
    mag = ang[k+1] - ang[k];
    if (mag < 0) mag = -mag;
    q = (phase - knot[k]) * mag / (knot[k+1] - knot[k]);
    return (ang[k] < ang[k+1]) ? ang[k] + q : ang[k] - q;
  endfunction

  // expected command words for one accepted gait update
  task automatic predict_update(input logic [LEG_W-1:0] la, input logic [LEG_W-1:0] lb,
                                input logic [LEG_W-1:0] lc, input logic [PHASE_W-1:0] offs,
                                input logic [PER_W-1:0] per);
    logic [LEG_W-1:0]  legs [3];
    logic [PROD_W-1:0] travel;
    int                phase;
    int                ang;
    int                idx;
    int                n;
    int                i;
    int                j;
    engine_cmd_t       cmd;
    legs[0] = la;
    legs[1] = lb;
    legs[2] = lc;
    travel = PROD_W'(per) * PROD_W'(speed);
    phase = (32'(travel) + 32'(offs)) & 1023;
    if (offs == '0) step_cnt = travel[PROD_W-1:PHASE_W];
    n = 0;
    for (i = 0; i < 3; i++) begin
      if (legs[i] < NUM_LEGS) begin
        for (j = 0; j < 3; j++) begin
          ang = joint_angle(j, phase);
          idx = legs[i] * 3 + j;
          if (kept_angle[idx] != ang) begin
            kept_angle[idx] = ang;
            cmd.engine = ID_W'(legs[i] * 10 + j);
            cmd.angle  = ANG_W'(ang);
            cmd.steps  = step_cnt;
            cmd.last   = 1'b0;
            cmd_due.push_back(cmd);
            n++;
          end
        end
      end
    end
    // tag the final word of this update
    if (n > 0) begin
      cmd = cmd_due[cmd_due.size()-1];
      cmd.last = 1'b1;
      cmd_due[cmd_due.size()-1] = cmd;
    end
  endtask

  // compare leaving words first, then take config and new updates
  always @(posedge clk_i or negedge rst_ni) begin : watch
    engine_cmd_t want;
    if (!rst_ni) begin
      speed = 5'd5;
      step_cnt = '0;
      foreach (kept_angle[e]) kept_angle[e] = 0;
      cmd_due.delete();
      fail_cnt_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cmd_due.size() == 0) begin
          $display("%0t: unexpected word: engine %0d angle %0d steps %0d last %0b",
                   $time, engine_id_i, angle_i, steps_done_i, last_of_run_i);
          fail_cnt_o++;
        end else begin
          want = cmd_due.pop_front();
          if (engine_id_i != want.engine) begin
            $display("%0t: engine_id expected %0d actual %0d",
                     $time, want.engine, engine_id_i);
            fail_cnt_o++;
          end
          if (angle_i != want.angle) begin
            $display("%0t: angle (engine %0d) expected %0d actual %0d",
                     $time, want.engine, $signed(want.angle), angle_i);
            fail_cnt_o++;
          end
          if (steps_done_i != want.steps) begin
            $display("%0t: steps_done (engine %0d) expected %0d actual %0d",
                     $time, want.engine, want.steps, steps_done_i);
            fail_cnt_o++;
          end
          if (last_of_run_i != want.last) begin
            $display("%0t: last_of_run (engine %0d) expected %0b actual %0b",
                     $time, want.engine, want.last, last_of_run_i);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) speed = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        predict_update(leg_a_i, leg_b_i, leg_c_i, phase_offset_i, elapsed_periods_i);
    end
    due_cnt_o = cmd_due.size();
  end

endmodule

// File: tb/sv/tb_gait_piecewise_linear_joint_gen.sv
`timescale 1ns / 100ps
// tb_gait_piecewise_linear_joint_gen: drives gait updates and speed settings into the
// joint generator with random gaps and stalls; gait_cmd_checker does the checking.
// Depends on gpljg_pkg, gait_piecewise_linear_joint_gen and gait_cmd_checker.
module tb_gait_piecewise_linear_joint_gen;
  import gpljg_pkg::*;

  localparam int RUN_LIMIT = 500000;
  localparam int SETTLE    = 100;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [SPP_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [LEG_W-1:0]        leg_a;
  logic [LEG_W-1:0]        leg_b;
  logic [LEG_W-1:0]        leg_c;
  logic [PHASE_W-1:0]      phase_offset;
  logic [PER_W-1:0]        elapsed_periods;
  logic                    out_valid;
  logic                    out_stall;
  logic [ID_W-1:0]         engine_id;
  logic signed [ANG_W-1:0] angle;
  logic [STEP_W-1:0]       steps_done;
  logic                    last_of_run;
  int                      fail_cnt;
  int                      due_cnt;
  int                      cycle_cnt;
  bit                      tx_calm;

  gait_piecewise_linear_joint_gen dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .leg_a_i           (leg_a),
    .leg_b_i           (leg_b),
    .leg_c_i           (leg_c),
    .phase_offset_i    (phase_offset),
    .elapsed_periods_i (elapsed_periods),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .engine_id_o       (engine_id),
    .angle_o           (angle),
    .steps_done_o      (steps_done),
    .last_of_run_o     (last_of_run)
  );

  gait_cmd_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .leg_a_i           (leg_a),
    .leg_b_i           (leg_b),
    .leg_c_i           (leg_c),
    .phase_offset_i    (phase_offset),
    .elapsed_periods_i (elapsed_periods),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .engine_id_i       (engine_id),
    .angle_i           (angle),
    .steps_done_i      (steps_done),
    .last_of_run_i     (last_of_run),
    .fail_cnt_o        (fail_cnt),
    .due_cnt_o         (due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop on a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_gait_piecewise_linear_joint_gen: FAIL");
    $finish;
  end

  // command sink: random stall before each word, with calm stretches
  initial begin : sink
    int  hold;
    int  left;
    bit  calm;
    out_stall <= 1'b0;
    left = 0;
    calm = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        left = $urandom_range(8, 24);
      end
      left--;
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // one gait update word, after a random gap
  task automatic send_update(input logic [LEG_W-1:0] la, input logic [LEG_W-1:0] lb,
                             input logic [LEG_W-1:0] lc, input logic [PHASE_W-1:0] offs,
                             input logic [PER_W-1:0] per);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    leg_a           <= la;
    leg_b           <= lb;
    leg_c           <= lc;
    phase_offset    <= offs;
    elapsed_periods <= per;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every expected word is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_cnt != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_speed(input logic [SPP_W-1:0] spp);
    cfg_we    <= 1'b1;
    cfg_wdata <= spp;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly tripod walks with rising period count, some random noise words
  task automatic run_walk(input int n_items);
    int              sent;
    int              seg;
    int              k;
    int              side;
    logic [PER_W-1:0] per;
    logic [PHASE_W-1:0] half;
    sent = 0;
    while (sent < n_items) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       per = '0;
          1:       per = '1;
          default: per = PER_W'($urandom);
        endcase
        send_update(LEG_W'($urandom_range(0, 7)), LEG_W'($urandom_range(0, 7)),
                    LEG_W'($urandom_range(0, 7)),
                    ($urandom_range(0, 2) == 0) ? '0 : PHASE_W'($urandom), per);
        sent++;
      end else begin
        seg  = $urandom_range(3, 10);
        side = $urandom_range(0, 1);
        per  = ($urandom_range(0, 3) == 0) ? PER_W'('1) - PER_W'(seg / 2)
                                           : PER_W'($urandom);
        half = ($urandom_range(0, 2) == 0) ? PHASE_W'($urandom_range(1, 1023))
                                           : PHASE_W'(512);
        for (k = 0; k < seg; k++) begin
          send_update(LEG_W'(side), LEG_W'(side + 2), LEG_W'(side + 4), '0, per);
          send_update(LEG_W'(5 - side), LEG_W'(3 - side), LEG_W'(1 - side), half, per);
          per = per + 1'b1;
          sent += 2;
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    leg_a           <= '0;
    leg_b           <= '0;
    leg_c           <= '0;
    phase_offset    <= '0;
    elapsed_periods <= '0;
    tx_calm         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: breakpoints, leg range, step count edges, at reset speed
    send_update(0, 1, 2, 0, 0);
    send_update(0, 1, 2, 0, 0);
    send_update(3, 4, 5, 85, 0);
    send_update(0, 2, 4, 427, 0);
    send_update(1, 3, 5, 512, 0);
    send_update(0, 1, 2, 597, 0);
    send_update(3, 4, 5, 939, 0);
    send_update(6, 7, 0, 1023, 0);
    send_update(7, 7, 7, 300, 0);
    send_update(5, 5, 5, 0, '1);
    send_update(0, 0, 0, 1023, '1);
    send_update(2, 6, 4, 0, 1);
    send_update(1, 3, 5, 200, 12345);
    send_update(4, 3, 2, 0, 204);
    send_update(0, 1, 2, 0, 205);
    send_update(5, 4, 3, 1, 24'h800000);
    drain();

    // random phases over several speeds, extremes included
    set_speed(5'd31);
    send_update(1, 2, 3, 0, '1);
    run_walk(48);
    drain();
    set_speed(5'd0);
    run_walk(40);
    drain();
    set_speed(5'd20);
    run_walk(48);
    drain();
    set_speed(5'd1);
    run_walk(48);
    drain();
    set_speed(SPP_W'($urandom_range(2, 30)));
    run_walk(48);
    drain();
    set_speed(5'd5);
    run_walk(48);
    drain();

    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("tb_gait_piecewise_linear_joint_gen: PASS");
    end else begin
      $display("tb_gait_piecewise_linear_joint_gen: FAIL");
    end
    $finish;
  end

endmodule
